[sv/kmcl_pkg.sv]
// ----------------------------------------------------------------------------
// kmcl_pkg
// Screen and entry codes, keypad key codes and defaults for the code lock.
// ----------------------------------------------------------------------------
`default_nettype none

package kmcl_pkg;

  typedef enum logic [2:0] {
    SCR_START    = 3'd0,
    SCR_GREET    = 3'd1,
    SCR_MENU     = 3'd2,
    SCR_DOWNLOAD = 3'd3,
    SCR_PROMPT   = 3'd4,
    SCR_ENTRY    = 3'd5,
    SCR_WRONG    = 3'd6,
    SCR_CORRECT  = 3'd7
  } screen_t;

  typedef enum logic [3:0] {
    EN_IDLE    = 4'd0,
    EN_CLEAR   = 4'd1,
    EN_WAIT    = 4'd2,
    EN_STORE   = 4'd3,
    EN_RELEASE = 4'd4,
    EN_COUNT   = 4'd5,
    EN_COMPARE = 4'd6,
    EN_WRONG   = 4'd7,
    EN_CORRECT = 4'd8
  } entry_t;

  localparam logic [7:0]  KEY_NONE = 8'h00;
  localparam logic [7:0]  KEY_STAR = 8'h2A;
  localparam logic [7:0]  KEY_C    = 8'h43;
  localparam logic [7:0]  KEY_ONE  = 8'h31;
  localparam logic [7:0]  KEY_ZERO = 8'h30;
  localparam logic [7:0]  KEY_NINE = 8'h39;

  localparam int          CODE_LENGTH_DEF = 4;
  localparam logic [31:0] SECRET_RESET    = 32'h3230_3033;
  localparam logic [1:0]  ADDR_SECRET     = 2'd0;

endpackage

`default_nettype wire

[sv/keypad_menu_code_lock.sv]
// ----------------------------------------------------------------------------
// keypad_menu_code_lock
// Keypad menu and code lock: one key beat in, one screen/code beat out.
// ----------------------------------------------------------------------------
// channel   | signals                                   | dir
// key       | key_valid, key_ready, key[7:0]            | in
// result    | result_valid, result_ready, screen,       | out
//           | digits_entered, entered_code              |
// config    | psel, penable, pwrite, paddr, pwdata,     | in/out
//           | prdata, pready                            |
// One key beat is taken per cycle; its result appears the cycle after.
// Both state machines step in the same cycle, from the state registers,
// which double as the result register.
// A key beat is taken while the result slot is empty or being drained,
// so a stalled result holds the machines and the key channel together.
// Reset is synchronous: menu at start, entry idle, buffer and count zero,
// secret code back to its default; no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_menu_code_lock #(
  parameter int CODE_LENGTH = kmcl_pkg::CODE_LENGTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        key_valid,
  output logic             key_ready,
  input  wire logic [7:0]  key,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic [2:0]       screen,
  output logic [2:0]       digits_entered,
  output logic [31:0]      entered_code,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import kmcl_pkg::*;

  localparam int CW    = $clog2(CODE_LENGTH + 1);
  localparam int SHOWN = (CODE_LENGTH < 4) ? CODE_LENGTH : 4;

  logic [31:0]   secret_code;
  screen_t       menu_state, menu_state_next;
  entry_t        entry_state, entry_state_next;
  logic [CW-1:0] digit_count, digit_count_next;
  logic [7:0]    digit_buffer [CODE_LENGTH];
  logic [7:0]    digit_buffer_next [CODE_LENGTH];
  logic [7:0]    expected [CODE_LENGTH];
  logic [CW-1:0] count_inc;
  logic [CW+2:0] count_ext;
  logic          match;
  logic          is_digit;
  logic          take;

  assign take      = key_valid && key_ready;
  assign key_ready = !result_valid || result_ready;
  assign is_digit  = (key >= KEY_ZERO) && (key <= KEY_NINE);
  assign count_inc = digit_count + CW'(1);

  // config port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_SECRET) prdata = secret_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      secret_code <= SECRET_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_SECRET) begin
      secret_code <= pwdata;
    end
  end

  // expected bytes, zero past the fourth
  for (genvar g = 0; g < CODE_LENGTH; g++) begin : g_exp
    if (g < 4) begin : g_in
      assign expected[g] = secret_code[8*(3-g) +: 8];
    end else begin : g_out
      assign expected[g] = 8'h00;
    end
  end

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (digit_buffer[i] != expected[i]) match = 1'b0;
    end
  end

  // menu next state
  always_comb begin
    menu_state_next = menu_state;
    unique case (menu_state)
      SCR_START:  menu_state_next = SCR_GREET;
      SCR_GREET:  menu_state_next = SCR_MENU;
      SCR_MENU: begin
        if (key == KEY_ONE) menu_state_next = SCR_DOWNLOAD;
        if (key == KEY_C)   menu_state_next = SCR_PROMPT;
      end
      SCR_PROMPT: menu_state_next = SCR_ENTRY;
      SCR_ENTRY: begin
        if (entry_state == EN_CORRECT) menu_state_next = SCR_CORRECT;
        if (entry_state == EN_WRONG)   menu_state_next = SCR_WRONG;
      end
      SCR_DOWNLOAD, SCR_WRONG, SCR_CORRECT: begin
        if (key == KEY_STAR) menu_state_next = SCR_MENU;
      end
      default: menu_state_next = SCR_START;
    endcase
  end

  // entry next state
  always_comb begin
    entry_state_next = entry_state;
    unique case (entry_state)
      EN_IDLE:    if (menu_state_next == SCR_PROMPT) entry_state_next = EN_CLEAR;
      EN_CLEAR:   entry_state_next = EN_WAIT;
      EN_WAIT:    if (is_digit) entry_state_next = EN_STORE;
      EN_STORE:   entry_state_next = EN_RELEASE;
      EN_RELEASE: if (key == KEY_NONE) entry_state_next = EN_COUNT;
      EN_COUNT: begin
        entry_state_next = (count_inc < CW'(CODE_LENGTH)) ? EN_WAIT : EN_COMPARE;
      end
      EN_COMPARE: entry_state_next = match ? EN_CORRECT : EN_WRONG;
      EN_WRONG:   if (menu_state_next == SCR_WRONG) entry_state_next = EN_IDLE;
      EN_CORRECT: if (menu_state_next == SCR_CORRECT) entry_state_next = EN_IDLE;
      default:    entry_state_next = EN_IDLE;
    endcase
  end

  // count and buffer
  always_comb begin
    digit_count_next = digit_count;
    for (int i = 0; i < CODE_LENGTH; i++) digit_buffer_next[i] = digit_buffer[i];
    case (entry_state)
      EN_CLEAR: begin
        digit_count_next = '0;
        for (int i = 0; i < CODE_LENGTH; i++) digit_buffer_next[i] = 8'h00;
      end
      EN_STORE: begin
        for (int i = 0; i < CODE_LENGTH; i++) begin
          if (digit_count == CW'(i)) digit_buffer_next[i] = key;
        end
      end
      EN_COUNT:   digit_count_next = count_inc;
      EN_COMPARE: digit_count_next = CW'(CODE_LENGTH);
      default:    digit_count_next = digit_count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      menu_state   <= SCR_START;
      entry_state  <= EN_IDLE;
      digit_count  <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < CODE_LENGTH; i++) digit_buffer[i] <= 8'h00;
    end else begin
      if (take) begin
        menu_state  <= menu_state_next;
        entry_state <= entry_state_next;
        digit_count <= digit_count_next;
        for (int i = 0; i < CODE_LENGTH; i++) digit_buffer[i] <= digit_buffer_next[i];
      end
      if (take)              result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

  // result beat
  assign count_ext = {3'b000, digit_count};
  always_comb begin
    screen         = menu_state;
    digits_entered = count_ext[2:0];
    entered_code   = '0;
    for (int i = 0; i < SHOWN; i++) begin
      entered_code[8*(3-i) +: 8] = digit_buffer[i];
    end
  end

endmodule

`default_nettype wire

[sv/kmcl_checker.sv]
// ----------------------------------------------------------------------------
// kmcl_checker
// Port-level checks on the keypad code lock, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kmcl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        key_valid,
  input wire logic        key_ready,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire logic [2:0]  screen,
  input wire logic [31:0] entered_code
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result beat dropped while stalled");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    key_ready == (!result_valid || result_ready))
    else $error("key ready does not follow free result slot");

  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    key_valid && key_ready |=> result_valid)
    else $error("key beat gave no result beat");

  a_screen_hold: assert property (@(posedge clk) disable iff (rst)
    !(key_valid && key_ready) |=> $stable(screen) && $stable(entered_code))
    else $error("screen or code moved without a key beat");

endmodule

bind keypad_menu_code_lock kmcl_checker u_kmcl_checker (
  .clk          (clk),
  .rst          (rst),
  .key_valid    (key_valid),
  .key_ready    (key_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .screen       (screen),
  .entered_code (entered_code)
);

`default_nettype wire
